@@ hdl/cdsr_pkg.sv @@
// Shared types, constants and helper functions for the CD audio subcode deframer.
package cdsr_pkg;

   // Field widths of the channels.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int QVAL_W   = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 1;

   // Block layout of one raw read block.
   localparam int BLOCK_BYTES      = 2368;
   localparam int SAMPLES_IN_BLOCK = 588;
   localparam int AUDIO_BYTES      = SAMPLES_IN_BLOCK * 4;
   localparam int Q_BYTES          = 16;
   localparam int OFFSET_W         = 12;

   // Request operation codes.
   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REVERSE_PLAY = 1'b0,
      CSR_SWAP_BYTES   = 1'b1
   } csr_index_type;

   // Decodes one BCD byte; a digit above nine makes the whole value zero.
   function automatic logic [QVAL_W-1:0] bcd_value(input logic [BYTE_W-1:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      logic [QVAL_W-1:0] val;
      hi = b[7:4];
      lo = b[3:0];
      if (hi > 4'd9 || lo > 4'd9) begin
         val = '0;
      end else begin
         val = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
      end
      return val;
   endfunction

endpackage

@@ hdl/cdsr_if.sv @@
// Channel interfaces for the request, response and configuration transfers.
interface cdsr_req_if;
   import cdsr_pkg::*;
   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, output opcode, output data_byte, output last_byte,
                   input ready);
   modport sink (input valid, input opcode, input data_byte, input last_byte,
                 output ready);
endinterface

interface cdsr_rsp_if;
   import cdsr_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] sample_word;
   logic              sample_last;
   logic [QVAL_W-1:0] q_track;
   logic [QVAL_W-1:0] q_index;
   logic [QVAL_W-1:0] q_frame;
   logic              q_seen;
   modport source (output valid, output sample_word, output sample_last, output q_track,
                   output q_index, output q_frame, output q_seen, input ready);
   modport sink (input valid, input sample_word, input sample_last, input q_track,
                 input q_index, input q_frame, input q_seen, output ready);
endinterface

interface cdsr_csr_if;
   import cdsr_pkg::*;
   logic                 valid;
   logic                 ready;
   csr_index_type        index;
   logic [CSR_DAT_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/cdda_subcode_strip_reorder.sv @@
// Top level of the CD audio raw-read deframer with Q-subchannel decode and reverse store.

// The block takes raw CD audio read bytes in 2368-byte blocks, strips the 16 trailing
// Q-subchannel bytes, decodes track, index and frame from Q data whose first byte is 1,
// and emits one 32-bit stereo word per four audio bytes, byte-swapped per sample when
// swap_bytes is set. In reverse mode the words are written to a single-port sample
// store of STORE_WORDS entries and are read back last-first by drain ticks; a tick
// that finds words holds the request side in S_READ, since the store's read data is
// registered before it goes to the response register. The request side is also held
// while the response register holds a word that has not been taken. The store needs no
// clearing pass after reset: only entries below the stored count are ever read.
module cdda_subcode_strip_reorder #(
   parameter int STORE_WORDS = 16384
) (
   input logic         clock,
   input logic         reset,
   cdsr_req_if.sink    req_ch,
   cdsr_rsp_if.source  rsp_ch,
   cdsr_csr_if.sink    csr_ch
);
   import cdsr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_WORDS);
   localparam int CNT_W  = $clog2(STORE_WORDS + 1);

   typedef enum logic [0:0] {
      S_IDLE,
      S_READ
   } state_type;

   state_type         state_ff;
   state_type         state_in;

   // Configuration registers.
   logic              reverse_ff;
   logic              swap_ff;

   // Block position and word assembly.
   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [23:0]         assembly_ff;
   logic [23:0]         assembly_in;

   // Captured Q bytes used by the decode.
   logic [BYTE_W-1:0] q0_ff;
   logic [BYTE_W-1:0] q1_ff;
   logic [BYTE_W-1:0] q2_ff;
   logic [BYTE_W-1:0] q9_ff;

   // Decoded Q values.
   logic [QVAL_W-1:0] dq_track_ff;
   logic [QVAL_W-1:0] dq_index_ff;
   logic [QVAL_W-1:0] dq_frame_ff;
   logic              dq_seen_ff;

   // Sample store and its counters.
   logic [WORD_W-1:0] store_mem [STORE_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  drain_ff;
   logic [CNT_W-1:0]  drain_in;
   logic              fin_pend_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_last_ff;
   logic [QVAL_W-1:0] rsp_track_ff;
   logic [QVAL_W-1:0] rsp_index_ff;
   logic [QVAL_W-1:0] rsp_frame_ff;
   logic              rsp_seen_ff;

   logic              req_fire;
   logic              is_tick;
   logic              audio_zone;
   logic              word_done;
   logic              q_decode;
   logic              drain_hit;
   logic              store_wr;
   logic              fwd_emit;
   logic              rd_en;
   logic [WORD_W-1:0] word;
   logic [CNT_W-1:0]  rd_diff;
   logic [CNT_W-1:0]  drain_next;
   logic              drain_fin;

   // Handshakes: configuration is always taken; requests wait for an idle sequencer and a free response slot.
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_tick      = (req_ch.opcode == OP_TICK);

   // Byte classification within the block.
   assign audio_zone = (offset_ff < OFFSET_W'(AUDIO_BYTES));
   assign word_done  = !is_tick && audio_zone && (offset_ff[1:0] == 2'd3);
   assign q_decode   = req_fire && !is_tick && !audio_zone && (offset_ff[3:0] == 4'hF)
                       && (q0_ff == 8'd1);

   // Stereo word with optional per-sample byte swap.
   always_comb begin
      if (swap_ff) begin
         word = {assembly_ff[15:8], assembly_ff[7:0], req_ch.data_byte, assembly_ff[23:16]};
      end else begin
         word = {assembly_ff[7:0], assembly_ff[15:8], assembly_ff[23:16], req_ch.data_byte};
      end
   end

   // Store write, forward emission and drain read decisions.
   assign store_wr   = req_fire && word_done && reverse_ff && (drain_ff == '0)
                       && (count_ff < CNT_W'(STORE_WORDS));
   assign fwd_emit   = req_fire && word_done && !reverse_ff;
   assign drain_hit  = (count_ff != '0) && (drain_ff < count_ff);
   assign rd_en      = req_fire && is_tick && drain_hit;
   assign rd_diff    = count_ff - CNT_W'(1) - drain_ff;
   assign drain_next = drain_ff + CNT_W'(1);
   assign drain_fin  = (drain_next >= count_ff);

   // Next block offset and assembly contents.
   always_comb begin
      offset_in   = offset_ff;
      assembly_in = assembly_ff;
      if (req_fire && !is_tick) begin
         if (audio_zone) begin
            case (offset_ff[1:0])
               2'd0: assembly_in[7:0]   = req_ch.data_byte;
               2'd1: assembly_in[15:8]  = req_ch.data_byte;
               2'd2: assembly_in[23:16] = req_ch.data_byte;
               default: assembly_in     = '0;
            endcase
         end
         if (offset_ff == OFFSET_W'(BLOCK_BYTES - 1)) begin
            offset_in = '0;
         end else begin
            offset_in = offset_ff + OFFSET_W'(1);
         end
         if (req_ch.last_byte) begin
            offset_in   = '0;
            assembly_in = '0;
         end
      end
   end

   // Next store count and drain pointer.
   always_comb begin
      count_in = count_ff;
      drain_in = drain_ff;
      if (store_wr) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en) begin
         if (drain_fin) begin
            count_in = '0;
            drain_in = '0;
         end else begin
            drain_in = drain_next;
         end
      end
   end

   // Control and decoded-value registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff  <= 1'b0;
         swap_ff     <= 1'b1;
         offset_ff   <= '0;
         assembly_ff <= '0;
         dq_track_ff <= '0;
         dq_index_ff <= '0;
         dq_frame_ff <= '0;
         dq_seen_ff  <= 1'b0;
         count_ff    <= '0;
         drain_ff    <= '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_REVERSE_PLAY: reverse_ff <= csr_ch.wdata[0];
               CSR_SWAP_BYTES:   swap_ff    <= csr_ch.wdata[0];
               default:          ;
            endcase
         end
         offset_ff   <= offset_in;
         assembly_ff <= assembly_in;
         count_ff    <= count_in;
         drain_ff    <= drain_in;
         if (q_decode) begin
            dq_track_ff <= bcd_value(q1_ff);
            dq_index_ff <= bcd_value(q2_ff);
            dq_frame_ff <= bcd_value(q9_ff);
            dq_seen_ff  <= 1'b1;
         end
      end
   end

   // Q byte and drain-last capture; every captured Q byte is written earlier in the same block than its decode.
   always_ff @(posedge clock) begin
      if (req_fire && !is_tick && !audio_zone) begin
         case (offset_ff[3:0])
            4'd0:    q0_ff <= req_ch.data_byte;
            4'd1:    q1_ff <= req_ch.data_byte;
            4'd2:    q2_ff <= req_ch.data_byte;
            4'd9:    q9_ff <= req_ch.data_byte;
            default: ;
         endcase
      end
      if (rd_en) begin
         fin_pend_ff <= drain_fin;
      end
   end

   // Sample store with a registered read port.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[count_ff[ADDR_W-1:0]] <= word;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_diff[ADDR_W-1:0]];
      end
   end

   // Sequencer state and response register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (rd_en) state_in = S_READ;
         S_READ:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fwd_emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= word;
            rsp_last_ff  <= req_ch.last_byte;
         end else if (state_ff == S_READ) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= rd_data_ff;
            rsp_last_ff  <= fin_pend_ff;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fwd_emit || state_ff == S_READ) begin
            rsp_track_ff <= dq_track_ff;
            rsp_index_ff <= dq_index_ff;
            rsp_frame_ff <= dq_frame_ff;
            rsp_seen_ff  <= dq_seen_ff;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.sample_word = rsp_word_ff;
   assign rsp_ch.sample_last = rsp_last_ff;
   assign rsp_ch.q_track     = rsp_track_ff;
   assign rsp_ch.q_index     = rsp_index_ff;
   assign rsp_ch.q_frame     = rsp_frame_ff;
   assign rsp_ch.q_seen      = rsp_seen_ff;

endmodule

@@ hdl/cdsr_checker.sv @@
// Port-level assertions for the deframer and the bind that attaches them.
module cdsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sample_word,
   input logic        rsp_q_seen
);
   logic seen_ff;

   // Remembers that a transfer has already reported decoded Q data.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_q_seen) begin
         seen_ff <= 1'b1;
      end
   end

   // A stalled response keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_word))
      else $error("stalled response changed");

   // A request is taken only when the response register is free or being freed.
   a_req_slot: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while response blocked");

   // Once decoded Q data has been reported, it stays reported.
   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |-> rsp_q_seen)
      else $error("q_seen dropped after being reported");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cdda_subcode_strip_reorder cdsr_checker u_cdsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_sample_word (rsp_ch.sample_word),
   .rsp_q_seen      (rsp_ch.q_seen)
);
